FILE: rtl/spcp_pkg.sv
// Shared widths and bundle types for the segment pair closest points pipeline.
// No dependencies; imported by segment_pair_closest_points.
`timescale 1ns / 1ps

package spcp_pkg;

	localparam int CW   = 32;          // coordinate width
	localparam int DW   = CW + 1;      // endpoint difference width
	localparam int PRW  = 2 * DW;      // difference product width
	localparam int DOTW = PRW + 2;     // dot product width
	localparam int MW   = PRW;         // dot product magnitude width
	localparam int HW   = MW / 2;      // magnitude half width
	localparam int PW   = 2 * MW;      // second order product magnitude width
	localparam int SW   = PW + 2;      // signed second order width
	localparam int MULW = PW + CW;     // numerator times direction width
	localparam int NUMW = MULW + 2;    // rounded dividend width
	localparam int QW   = CW + 1;      // quotient width
	localparam int RW   = PW + 1;      // partial remainder width
	localparam int THW  = 16;          // threshold width
	localparam int LAT  = 14 + QW;     // stages from transfer to result

	typedef struct packed {
		logic [2:0][CW-1:0] base_a;
		logic [2:0][CW-1:0] base_c;
		logic [2:0][CW-1:0] mag_u;
		logic [2:0][CW-1:0] mag_v;
		logic [2:0]         neg_u;
		logic [2:0]         neg_v;
	} side_t;

	typedef struct packed {
		logic signed [DOTW-1:0] a;
		logic signed [DOTW-1:0] b;
		logic signed [DOTW-1:0] c;
		logic signed [DOTW-1:0] d;
		logic signed [DOTW-1:0] e;
		logic signed [DOTW:0]   e_pb;
		logic signed [DOTW:0]   b_md;
		logic signed [DOTW:0]   n_d;
	} dots_t;

endpackage

FILE: rtl/segment_pair_closest_points.sv
// Closest points between two 3D segments, fully pipelined.
// Depends on spcp_pkg for widths and bundle types.
// The result strobe done is raised when a transfer on start leaves the last stage of the valid pipeline.
// Throughput: one segment pair per cycle; busy stays low, nothing stalls.
// The 47 stages are 13 arithmetic stages, 33 quotient-bit divider stages, one output stage.
// Reset clears the valid pipeline and sets the threshold to zero.
`timescale 1ns / 1ps

module segment_pair_closest_points import spcp_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	input  logic           cfg_wr_en,
	input  logic [THW-1:0] cfg_wr_data,
	input  logic [CW-1:0]  first_start_x,
	input  logic [CW-1:0]  first_start_y,
	input  logic [CW-1:0]  first_start_z,
	input  logic [CW-1:0]  first_end_x,
	input  logic [CW-1:0]  first_end_y,
	input  logic [CW-1:0]  first_end_z,
	input  logic [CW-1:0]  second_start_x,
	input  logic [CW-1:0]  second_start_y,
	input  logic [CW-1:0]  second_start_z,
	input  logic [CW-1:0]  second_end_x,
	input  logic [CW-1:0]  second_end_y,
	input  logic [CW-1:0]  second_end_z,
	output logic [CW-1:0]  near_first_x,
	output logic [CW-1:0]  near_first_y,
	output logic [CW-1:0]  near_first_z,
	output logic [CW-1:0]  near_second_x,
	output logic [CW-1:0]  near_second_y,
	output logic [CW-1:0]  near_second_z
);

	localparam int IA = 0;
	localparam int IB = 1;
	localparam int IC = 2;
	localparam int ID = 3;
	localparam int IE = 4;
	localparam int PX [6] = '{IA, IB, IB, IC, IA, IB};
	localparam int PY [6] = '{IC, IB, IE, ID, IE, ID};

	logic [THW-1:0] thr_q;
	logic           vld_s [1:LAT];
	side_t          side_s [1:LAT-1];

	logic [2:0][CW-1:0] pa, pb, pc, pd;
	side_t              side_in;

	logic signed [DW-1:0]   u_s1 [3];
	logic signed [DW-1:0]   v_s1 [3];
	logic signed [DW-1:0]   w_s1 [3];
	logic signed [PRW-1:0]  pr_s2 [5][3];
	logic signed [DOTW-1:0] dot_s3 [5];
	dots_t                  dt_s [4:9];
	logic [MW-1:0]          mg_s4 [5];
	logic                   sg_s4 [5];
	logic [PRW-1:0]         pp_s5 [6][4];
	logic                   ps_s5 [6];
	logic [PW-1:0]          pm_s6 [6];
	logic                   ps_s6 [6];
	logic signed [SW-1:0]   det_s7, sn_s7, tn_s7;
	logic signed [SW-1:0]   sn_s8, sd_s8, tn_s8, td_s8;
	logic                   sf_s8;
	logic signed [SW-1:0]   sn_s9, sd_s9, tn_s9, td_s9;
	logic                   sf_s9;
	logic [PW-1:0]          num_s10 [2];
	logic [PW-1:0]          den_s10 [2];
	logic [2*CW-1:0]        mp_s11 [6][5];
	logic [PW-1:0]          den_s11 [2];
	logic [MULW-1:0]        mg_s12 [6];
	logic [PW-1:0]          den_s12 [2];
	logic [NUMW-1:0]        nm_s13 [6];
	logic [PW-1:0]          den_s13 [2];

	logic [RW-1:0] dr_s [0:QW-2][6];
	logic [QW-1:0] dl_s [0:QW-2][6];
	logic [PW-1:0] dd_s [0:QW-2][2];
	logic [QW-1:0] dq_s [0:QW-1][6];

	logic [CW-1:0] res_s47 [6];

	assign busy = 1'b0;
	assign done = vld_s[LAT];

	// stage 1 inputs
	assign pa = {first_start_z, first_start_y, first_start_x};
	assign pb = {first_end_z, first_end_y, first_end_x};
	assign pc = {second_start_z, second_start_y, second_start_x};
	assign pd = {second_end_z, second_end_y, second_end_x};

	always_comb begin
		logic signed [DW-1:0] du, dv;
		side_in = '0;
		for (int k = 0; k < 3; k++) begin
			du = $signed({pb[k][CW-1], pb[k]}) - $signed({pa[k][CW-1], pa[k]});
			dv = $signed({pd[k][CW-1], pd[k]}) - $signed({pc[k][CW-1], pc[k]});
			side_in.base_a[k] = pa[k];
			side_in.base_c[k] = pc[k];
			side_in.neg_u[k]  = du[DW-1];
			side_in.neg_v[k]  = dv[DW-1];
			side_in.mag_u[k]  = du[DW-1] ? CW'(-du) : du[CW-1:0];
			side_in.mag_v[k]  = dv[DW-1] ? CW'(-dv) : dv[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) vld_s[i] <= 1'b0;
		end else begin
			vld_s[1] <= start;
			for (int i = 2; i <= LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		side_s[1] <= side_in;
		for (int i = 2; i <= LAT-1; i++) side_s[i] <= side_s[i-1];
	end

	// stages 1 to 4: differences, products, dot sums, magnitudes
	always_comb begin
	end

	logic signed [DOTW-1:0] dabs [5];
	always_comb begin
		for (int i = 0; i < 5; i++) dabs[i] = dot_s3[i][DOTW-1] ? -dot_s3[i] : dot_s3[i];
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			u_s1[k] <= $signed({pb[k][CW-1], pb[k]}) - $signed({pa[k][CW-1], pa[k]});
			v_s1[k] <= $signed({pd[k][CW-1], pd[k]}) - $signed({pc[k][CW-1], pc[k]});
			w_s1[k] <= $signed({pa[k][CW-1], pa[k]}) - $signed({pc[k][CW-1], pc[k]});
			pr_s2[IA][k] <= u_s1[k] * u_s1[k];
			pr_s2[IB][k] <= u_s1[k] * v_s1[k];
			pr_s2[IC][k] <= v_s1[k] * v_s1[k];
			pr_s2[ID][k] <= u_s1[k] * w_s1[k];
			pr_s2[IE][k] <= v_s1[k] * w_s1[k];
		end
		for (int i = 0; i < 5; i++) begin
			dot_s3[i] <= DOTW'(pr_s2[i][0]) + DOTW'(pr_s2[i][1]) + DOTW'(pr_s2[i][2]);
			mg_s4[i]  <= dabs[i][MW-1:0];
			sg_s4[i]  <= dot_s3[i][DOTW-1];
		end
		dt_s[4].a    <= dot_s3[IA];
		dt_s[4].b    <= dot_s3[IB];
		dt_s[4].c    <= dot_s3[IC];
		dt_s[4].d    <= dot_s3[ID];
		dt_s[4].e    <= dot_s3[IE];
		dt_s[4].e_pb <= (DOTW+1)'(dot_s3[IE]) + (DOTW+1)'(dot_s3[IB]);
		dt_s[4].b_md <= (DOTW+1)'(dot_s3[IB]) - (DOTW+1)'(dot_s3[ID]);
		dt_s[4].n_d  <= -(DOTW+1)'(dot_s3[ID]);
		for (int i = 5; i <= 9; i++) dt_s[i] <= dt_s[i-1];
	end

	// stages 5 to 7: wide products as partial products, then det and numerators
	logic [PRW:0]         sum12 [6];
	logic signed [SW-1:0] sv [6];
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			sum12[i] = {1'b0, pp_s5[i][1]} + {1'b0, pp_s5[i][2]};
			sv[i] = ps_s6[i] ? -$signed(SW'(pm_s6[i])) : $signed(SW'(pm_s6[i]));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 6; i++) begin
			pp_s5[i][0] <= mg_s4[PX[i]][HW-1:0]  * mg_s4[PY[i]][HW-1:0];
			pp_s5[i][1] <= mg_s4[PX[i]][HW-1:0]  * mg_s4[PY[i]][MW-1:HW];
			pp_s5[i][2] <= mg_s4[PX[i]][MW-1:HW] * mg_s4[PY[i]][HW-1:0];
			pp_s5[i][3] <= mg_s4[PX[i]][MW-1:HW] * mg_s4[PY[i]][MW-1:HW];
			ps_s5[i]    <= sg_s4[PX[i]] ^ sg_s4[PY[i]];
			pm_s6[i]    <= {pp_s5[i][3], pp_s5[i][0]} + PW'({sum12[i], {HW{1'b0}}});
			ps_s6[i]    <= ps_s5[i];
		end
		det_s7 <= sv[0] - sv[1];
		sn_s7  <= sv[2] - sv[3];
		tn_s7  <= sv[4] - sv[5];
	end

	// stages 8 to 10: parallel test, clamps, zero tests
	logic signed [SW-1:0] thr_x;
	logic signed [SW-1:0] a9, c9, e9, epb9, x9;
	logic                 tneg9, tgt9;
	assign thr_x = $signed(SW'(thr_q));
	assign e9    = SW'(dt_s[7].e);
	assign c9    = SW'(dt_s[7].c);
	assign epb9  = SW'(dt_s[7].e_pb);
	assign a9    = SW'(dt_s[8].a);
	assign tneg9 = tn_s8[SW-1];
	assign tgt9  = tn_s8 > td_s8;
	assign x9    = tneg9 ? SW'(dt_s[8].n_d) : SW'(dt_s[8].b_md);

	always_ff @(posedge clk) begin
		if (det_s7 <= thr_x) begin
			sn_s8 <= '0; sd_s8 <= SW'(1); tn_s8 <= e9; td_s8 <= c9; sf_s8 <= 1'b0;
		end else if (sn_s7[SW-1]) begin
			sn_s8 <= '0; sd_s8 <= det_s7; tn_s8 <= e9; td_s8 <= c9; sf_s8 <= 1'b0;
		end else if (sn_s7 > det_s7) begin
			sn_s8 <= det_s7; sd_s8 <= det_s7; tn_s8 <= epb9; td_s8 <= c9; sf_s8 <= 1'b1;
		end else begin
			sn_s8 <= sn_s7; sd_s8 <= det_s7; tn_s8 <= tn_s7; td_s8 <= det_s7; sf_s8 <= 1'b0;
		end

		td_s9 <= td_s8;
		tn_s9 <= tneg9 ? '0 : (tgt9 ? td_s8 : tn_s8);
		if (!(tneg9 || tgt9)) begin
			sn_s9 <= sn_s8; sd_s9 <= sd_s8; sf_s9 <= sf_s8;
		end else if (x9[SW-1]) begin
			sn_s9 <= '0; sd_s9 <= sd_s8; sf_s9 <= 1'b0;
		end else if (x9 > a9) begin
			sn_s9 <= sd_s8; sd_s9 <= sd_s8; sf_s9 <= 1'b1;
		end else begin
			sn_s9 <= x9; sd_s9 <= a9; sf_s9 <= 1'b0;
		end

		if (sf_s9) begin
			num_s10[0] <= sd_s9[PW-1:0]; den_s10[0] <= sd_s9[PW-1:0];
		end else if (sn_s9 <= thr_x || sd_s9 == '0) begin
			num_s10[0] <= '0; den_s10[0] <= PW'(1);
		end else begin
			num_s10[0] <= sn_s9[PW-1:0]; den_s10[0] <= sd_s9[PW-1:0];
		end
		if (tn_s9 <= thr_x || td_s9 == '0) begin
			num_s10[1] <= '0; den_s10[1] <= PW'(1);
		end else begin
			num_s10[1] <= tn_s9[PW-1:0]; den_s10[1] <= td_s9[PW-1:0];
		end
	end

	// stages 11 to 13: numerator times direction, rounded dividend
	logic [CW-1:0] dmag [6];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dmag[k]   = side_s[10].mag_u[k];
			dmag[k+3] = side_s[10].mag_v[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 6; l++) begin
			for (int c = 0; c < 4; c++) begin
				mp_s11[l][c] <= num_s10[l/3][c*CW +: CW] * dmag[l];
			end
			mp_s11[l][4] <= (2*CW)'(num_s10[l/3][PW-1:4*CW]) * dmag[l];
			mg_s12[l] <= {mp_s11[l][4][PW-4*CW+CW-1:0], mp_s11[l][2], mp_s11[l][0]}
				+ MULW'({mp_s11[l][3], mp_s11[l][1], {CW{1'b0}}});
			nm_s13[l] <= {1'b0, mg_s12[l], 1'b0} + NUMW'(den_s12[l/3]);
		end
		den_s11 <= den_s10;
		den_s12 <= den_s11;
		den_s13 <= den_s12;
	end

	// stages 14 to 46: one quotient bit per stage
	logic [RW-1:0] rin_c  [0:QW-1][6];
	logic [QW-1:0] lin_c  [0:QW-1][6];
	logic [PW-1:0] din_c  [0:QW-1][2];
	logic [QW-1:0] qin_c  [0:QW-1][6];
	logic [RW-1:0] rout_c [0:QW-1][6];
	logic [QW-1:0] qout_c [0:QW-1][6];
	always_comb begin
		logic [RW:0] t;
		logic [RW:0] dv;
		for (int l = 0; l < 6; l++) begin
			rin_c[0][l] = nm_s13[l][NUMW-1:QW];
			lin_c[0][l] = nm_s13[l][QW-1:0];
			qin_c[0][l] = '0;
		end
		din_c[0] = den_s13;
		for (int k = 1; k < QW; k++) begin
			rin_c[k] = dr_s[k-1];
			lin_c[k] = dl_s[k-1];
			qin_c[k] = dq_s[k-1];
			din_c[k] = dd_s[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			for (int l = 0; l < 6; l++) begin
				t  = {rin_c[k][l], lin_c[k][l][QW-1-k]};
				dv = {1'b0, din_c[k][l/3], 1'b0};
				if (t >= dv) begin
					rout_c[k][l] = RW'(t - dv);
					qout_c[k][l] = {qin_c[k][l][QW-2:0], 1'b1};
				end else begin
					rout_c[k][l] = t[RW-1:0];
					qout_c[k][l] = {qin_c[k][l][QW-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < QW-1; k++) begin
			dr_s[k] <= rout_c[k];
			dl_s[k] <= lin_c[k];
			dd_s[k] <= din_c[k];
		end
		for (int k = 0; k < QW; k++) dq_s[k] <= qout_c[k];
	end

	// stage 47: apply sign, add base, saturate
	logic signed [CW+2:0] off_c [6];
	logic signed [CW+2:0] sum_c [6];
	logic [CW-1:0]        base_c [6];
	logic                 neg_c  [6];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			base_c[k]   = side_s[LAT-1].base_a[k];
			base_c[k+3] = side_s[LAT-1].base_c[k];
			neg_c[k]    = side_s[LAT-1].neg_u[k];
			neg_c[k+3]  = side_s[LAT-1].neg_v[k];
		end
		for (int l = 0; l < 6; l++) begin
			off_c[l] = neg_c[l] ? -$signed((CW+3)'(dq_s[QW-1][l]))
				: $signed((CW+3)'(dq_s[QW-1][l]));
			sum_c[l] = $signed({{3{base_c[l][CW-1]}}, base_c[l]}) + off_c[l];
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 6; l++) begin
			if (sum_c[l][CW+2:CW-1] == '0 || sum_c[l][CW+2:CW-1] == '1) begin
				res_s47[l] <= sum_c[l][CW-1:0];
			end else if (sum_c[l][CW+2]) begin
				res_s47[l] <= {1'b1, {(CW-1){1'b0}}};
			end else begin
				res_s47[l] <= {1'b0, {(CW-1){1'b1}}};
			end
		end
	end

	assign near_first_x  = res_s47[0];
	assign near_first_y  = res_s47[1];
	assign near_first_z  = res_s47[2];
	assign near_second_x = res_s47[3];
	assign near_second_y = res_s47[4];
	assign near_second_z = res_s47[5];

endmodule
